### rtl/rscg_pkg.sv
// ----------------------------------------------------------------------------
// rscg_pkg
// Shared widths, configuration register codes and types of the rotation
// source coordinate generator.
// ----------------------------------------------------------------------------
package rscg_pkg;

  // Largest destination dimension handled by the scan counters.
  localparam int MAX_DIM   = 4096;
  localparam int CNT_W     = $clog2(MAX_DIM);      // counter / dst coordinate width
  localparam int DIM_W     = 13;                   // width of the size registers
  localparam int COEF_W    = 12;                   // Q10 coefficient width
  localparam int Q_SHIFT   = 10;                   // fractional bits of the coefficients
  localparam int OFS_W     = CNT_W + 1;            // centred destination offset
  localparam int PROD_W    = OFS_W + COEF_W;       // one product
  localparam int SUM_W     = PROD_W + 1;           // sum of two products
  localparam int XS_W      = SUM_W - Q_SHIFT + 2;  // full precision source coordinate
  localparam int SRC_CW    = 14;                   // reported source coordinate width
  localparam int CFG_IDX_W = 3;

  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS   = 3'd0,
    CFG_SIN   = 3'd1,
    CFG_SRC_W = 3'd2,
    CFG_SRC_H = 3'd3,
    CFG_DST_W = 3'd4,
    CFG_DST_H = 3'd5
  } cfg_idx_e;

  // Working configuration, destination sizes already clamped.
  typedef struct packed {
    logic signed [COEF_W-1:0] cos_q10;
    logic signed [COEF_W-1:0] sin_q10;
    logic        [DIM_W-1:0]  src_width;
    logic        [DIM_W-1:0]  src_height;
    logic        [DIM_W-1:0]  dst_w_eff;
    logic        [DIM_W-1:0]  dst_h_eff;
  } cfg_t;

  // Current scan position handed from the counter to the multiply stage.
  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             last_col;
    logic             last_row;
  } pos_t;

  // Payload of the multiply stage register.
  typedef struct packed {
    logic [CNT_W-1:0]         col;
    logic [CNT_W-1:0]         row;
    logic                     last;
    logic signed [PROD_W-1:0] p_xc;
    logic signed [PROD_W-1:0] p_ys;
    logic signed [PROD_W-1:0] p_xs;
    logic signed [PROD_W-1:0] p_yc;
  } prod_t;

  // A size of zero acts as one, a size above the counter range as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > MAX_DIM_V) begin
      r = MAX_DIM_V;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

### rtl/rscg_scan_counter.sv
// ----------------------------------------------------------------------------
// rscg_scan_counter
// Raster scan position over the destination frame, column fastest.
// ----------------------------------------------------------------------------
module rscg_scan_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic                          restart_i,
  input  logic [rscg_pkg::DIM_W-1:0]    dst_w_i,
  input  logic [rscg_pkg::DIM_W-1:0]    dst_h_i,
  output rscg_pkg::pos_t                pos_o
);

  logic [rscg_pkg::CNT_W-1:0] col_q, col_d;
  logic [rscg_pkg::CNT_W-1:0] row_q, row_d;
  logic [rscg_pkg::CNT_W-1:0] cur_col, cur_row;
  logic                       last_col, last_row;

  // A restart takes effect on the transfer that carries it.
  assign cur_col = restart_i ? '0 : col_q;
  assign cur_row = restart_i ? '0 : row_q;

  // A counter at or past the last position counts as at the last one.
  assign last_col = {1'b0, cur_col} >= (dst_w_i - rscg_pkg::DIM_W'(1));
  assign last_row = {1'b0, cur_row} >= (dst_h_i - rscg_pkg::DIM_W'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : cur_row + rscg_pkg::CNT_W'(1);
      end else begin
        col_d = cur_col + rscg_pkg::CNT_W'(1);
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.col      = cur_col;
  assign pos_o.row      = cur_row;
  assign pos_o.last_col = last_col;
  assign pos_o.last_row = last_row;

endmodule

### rtl/rscg_mult_stage.sv
// ----------------------------------------------------------------------------
// rscg_mult_stage
// Centres the destination position and registers the four Q10 products.
// ----------------------------------------------------------------------------
module rscg_mult_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic                 downstream_ready_i,
  input  rscg_pkg::pos_t       pos_i,
  input  rscg_pkg::cfg_t       cfg_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output rscg_pkg::prod_t      prod_o
);

  logic                                 valid_q, valid_d;
  rscg_pkg::prod_t                      prod_q, prod_d;
  logic signed [rscg_pkg::OFS_W-1:0]    xd, yd;

  assign ready_o = !valid_q || downstream_ready_i;

  assign xd = $signed({1'b0, pos_i.col}) - $signed({1'b0, cfg_i.dst_w_eff[rscg_pkg::DIM_W-1:1]});
  assign yd = $signed({1'b0, pos_i.row}) - $signed({1'b0, cfg_i.dst_h_eff[rscg_pkg::DIM_W-1:1]});

  always_comb begin
    prod_d.col  = pos_i.col;
    prod_d.row  = pos_i.row;
    prod_d.last = pos_i.last_col && pos_i.last_row;
    prod_d.p_xc = rscg_pkg::PROD_W'(xd) * rscg_pkg::PROD_W'(cfg_i.cos_q10);
    prod_d.p_ys = rscg_pkg::PROD_W'(yd) * rscg_pkg::PROD_W'(cfg_i.sin_q10);
    prod_d.p_xs = rscg_pkg::PROD_W'(xd) * rscg_pkg::PROD_W'(cfg_i.sin_q10);
    prod_d.p_yc = rscg_pkg::PROD_W'(yd) * rscg_pkg::PROD_W'(cfg_i.cos_q10);
  end

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

### rtl/rscg_output_stage.sv
// ----------------------------------------------------------------------------
// rscg_output_stage
// Sums the products, floors by the Q10 scale, adds the source centre, checks
// the source bounds and holds the result for the output channel.
// ----------------------------------------------------------------------------
module rscg_output_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  rscg_pkg::prod_t                     prod_i,
  input  rscg_pkg::cfg_t                      cfg_i,
  output logic                                ready_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [rscg_pkg::CNT_W-1:0]          dst_col_o,
  output logic [rscg_pkg::CNT_W-1:0]          dst_row_o,
  output logic signed [rscg_pkg::SRC_CW-1:0]  src_x_o,
  output logic signed [rscg_pkg::SRC_CW-1:0]  src_y_o,
  output logic                                inside_res_o,
  output logic                                last_pixel_o
);

  localparam int XS_W = rscg_pkg::XS_W;
  localparam logic signed [XS_W-1:0] SAT_HI = XS_W'(2 ** (rscg_pkg::SRC_CW - 1) - 1);
  localparam logic signed [XS_W-1:0] SAT_LO = XS_W'(-(2 ** (rscg_pkg::SRC_CW - 1)));

  logic signed [rscg_pkg::SUM_W-1:0]           sum_x, sum_y;
  logic signed [rscg_pkg::SUM_W-rscg_pkg::Q_SHIFT-1:0] fl_x, fl_y;
  logic signed [XS_W-1:0]                      xs, ys, sw, sh, xs_sat, ys_sat;
  logic                                        in_bounds;
  logic                                        valid_q, valid_d;
  logic [rscg_pkg::CNT_W-1:0]                  col_q, row_q;
  logic signed [rscg_pkg::SRC_CW-1:0]          sx_q, sy_q;
  logic                                        inside_q, last_q;

  assign ready_o = !valid_q || out_ready_i;

  assign sum_x = rscg_pkg::SUM_W'(prod_i.p_xc) - rscg_pkg::SUM_W'(prod_i.p_ys);
  assign sum_y = rscg_pkg::SUM_W'(prod_i.p_xs) + rscg_pkg::SUM_W'(prod_i.p_yc);

  // Dropping the low bits of a two's complement value is a floor division.
  assign fl_x = sum_x[rscg_pkg::SUM_W-1:rscg_pkg::Q_SHIFT];
  assign fl_y = sum_y[rscg_pkg::SUM_W-1:rscg_pkg::Q_SHIFT];

  assign sw = $signed({{(XS_W - rscg_pkg::DIM_W){1'b0}}, cfg_i.src_width});
  assign sh = $signed({{(XS_W - rscg_pkg::DIM_W){1'b0}}, cfg_i.src_height});

  assign xs = XS_W'(fl_x) + $signed({{(XS_W - rscg_pkg::DIM_W + 1){1'b0}},
                                     cfg_i.src_width[rscg_pkg::DIM_W-1:1]});
  assign ys = XS_W'(fl_y) + $signed({{(XS_W - rscg_pkg::DIM_W + 1){1'b0}},
                                     cfg_i.src_height[rscg_pkg::DIM_W-1:1]});

  assign in_bounds = !xs[XS_W-1] && (xs < sw) && !ys[XS_W-1] && (ys < sh);

  always_comb begin
    xs_sat = xs;
    if (xs > SAT_HI) begin
      xs_sat = SAT_HI;
    end else if (xs < SAT_LO) begin
      xs_sat = SAT_LO;
    end
    ys_sat = ys;
    if (ys > SAT_HI) begin
      ys_sat = SAT_HI;
    end else if (ys < SAT_LO) begin
      ys_sat = SAT_LO;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      col_q    <= prod_i.col;
      row_q    <= prod_i.row;
      sx_q     <= xs_sat[rscg_pkg::SRC_CW-1:0];
      sy_q     <= ys_sat[rscg_pkg::SRC_CW-1:0];
      inside_q <= in_bounds;
      last_q   <= prod_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign dst_col_o    = col_q;
  assign dst_row_o    = row_q;
  assign src_x_o      = sx_q;
  assign src_y_o      = sy_q;
  assign inside_res_o = inside_q;
  assign last_pixel_o = last_q;

endmodule

### rtl/rotation_source_coordinate_generator_core.sv
// ----------------------------------------------------------------------------
// rotation_source_coordinate_generator_core
// Inverse mapping address generator for fixed point image rotation.
// ----------------------------------------------------------------------------
// Each transfer on the input channel asks for the next destination pixel of a
// raster scan; restart_i set on a transfer starts that pixel at (0,0). Each
// input transfer gives exactly one output transfer with the destination
// position, the rotated source coordinate, an inside flag for the source image
// and a mark on the last pixel of the frame, after which the scan wraps.
// The configuration channel writes the Q10 cosine and sine and the four image
// sizes; it is always ready. The user must write it only while the block is
// idle; the block itself does not enforce this. An item transferred on the
// input channel is registered in the multiply stage and then in the output
// register, which presents it on the output channel. Throughput is one item
// per cycle while the receiver does not stall, set by the two register
// stages: the multiply stage register holding four 13x12 bit products, and
// the output register after the sum, floor shift, centre add and bounds
// compare. When the receiver stalls, each stage holds its item; the input
// side keeps accepting until both stages are full, so a stall costs no
// throughput once released. Reset clears the scan to (0,0), empties both stages
// and loads the configuration with cosine 1024, sine 0 and all sizes 1.
// ----------------------------------------------------------------------------
module rotation_source_coordinate_generator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rscg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rscg_pkg::DIM_W-1:0]          cfg_data_i,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rscg_pkg::CNT_W-1:0]          dst_col_o,
  output logic [rscg_pkg::CNT_W-1:0]          dst_row_o,
  output logic signed [rscg_pkg::SRC_CW-1:0]  src_x_o,
  output logic signed [rscg_pkg::SRC_CW-1:0]  src_y_o,
  output logic                                inside_res_o,
  output logic                                last_pixel_o
);

  logic signed [rscg_pkg::COEF_W-1:0] cos_q, sin_q;
  logic [rscg_pkg::DIM_W-1:0]         src_w_q, src_h_q, dst_w_q, dst_h_q;
  rscg_pkg::cfg_t                     cfg;
  rscg_pkg::pos_t                     pos;
  rscg_pkg::prod_t                    prod;
  logic                               in_xfer;
  logic                               mul_valid, out_stage_ready;

  // Configuration registers. Writes beyond the register list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= rscg_pkg::COEF_W'(1024);
      sin_q   <= '0;
      src_w_q <= rscg_pkg::DIM_W'(1);
      src_h_q <= rscg_pkg::DIM_W'(1);
      dst_w_q <= rscg_pkg::DIM_W'(1);
      dst_h_q <= rscg_pkg::DIM_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rscg_pkg::CFG_COS:   cos_q   <= cfg_data_i[rscg_pkg::COEF_W-1:0];
        rscg_pkg::CFG_SIN:   sin_q   <= cfg_data_i[rscg_pkg::COEF_W-1:0];
        rscg_pkg::CFG_SRC_W: src_w_q <= cfg_data_i;
        rscg_pkg::CFG_SRC_H: src_h_q <= cfg_data_i;
        rscg_pkg::CFG_DST_W: dst_w_q <= cfg_data_i;
        rscg_pkg::CFG_DST_H: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Destination sizes are clamped once here for both the counter and the
  // centring offsets.
  assign cfg.cos_q10    = cos_q;
  assign cfg.sin_q10    = sin_q;
  assign cfg.src_width  = src_w_q;
  assign cfg.src_height = src_h_q;
  assign cfg.dst_w_eff  = rscg_pkg::eff_dim(dst_w_q);
  assign cfg.dst_h_eff  = rscg_pkg::eff_dim(dst_h_q);

  assign in_xfer = in_valid_i && in_ready_o;

  rscg_scan_counter u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_xfer),
    .restart_i (restart_i),
    .dst_w_i   (cfg.dst_w_eff),
    .dst_h_i   (cfg.dst_h_eff),
    .pos_o     (pos)
  );

  rscg_mult_stage u_mult (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (in_valid_i),
    .downstream_ready_i (out_stage_ready),
    .pos_i              (pos),
    .cfg_i              (cfg),
    .ready_o            (in_ready_o),
    .valid_o            (mul_valid),
    .prod_o             (prod)
  );

  rscg_output_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (mul_valid),
    .prod_i       (prod),
    .cfg_i        (cfg),
    .ready_o      (out_stage_ready),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .dst_col_o    (dst_col_o),
    .dst_row_o    (dst_row_o),
    .src_x_o      (src_x_o),
    .src_y_o      (src_y_o),
    .inside_res_o (inside_res_o),
    .last_pixel_o (last_pixel_o)
  );

  // A restarting transfer always enters the pipeline at pixel (0,0).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && restart_i |=> mul_valid && prod.col == '0 && prod.row == '0)
    else $error("restart did not start the scan at the origin");

  // The input side only stalls when both stages hold an item and the
  // receiver is not taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> mul_valid && out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // An item in the multiply stage moves on whenever the output stage has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_valid && out_stage_ready |=> out_valid_o)
    else $error("item lost between the stages");

  // After the last pixel of the frame the scan wraps to the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && pos.last_col && pos.last_row |=> prod.col == '0 && prod.row == '0 ||
      !in_valid_i || restart_i || !in_ready_o || pos.col == '0 && pos.row == '0)
    else $error("scan did not wrap after the last pixel");

endmodule
